// ===== rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int WordW     = 32;
  localparam int NumDigest = 5;
  localparam int BlkWords  = 16;
  localparam int NumRounds = 80;
  localparam int RoundW    = 7;
  localparam int IdxW      = 3;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  // input op codes
  localparam logic [1:0] OpAbsorb = 2'd0;
  localparam logic [1:0] OpLast   = 2'd1;
  localparam logic [1:0] OpFinish = 2'd2;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumDigest - 1);

  typedef logic [NumDigest-1:0][WordW-1:0] digest_t;

  localparam digest_t InitChain = {
    32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  // block buffer / message schedule control
  typedef struct packed {
    logic       wr_byte;
    logic [5:0] byte_pos;
    logic [7:0] byte_val;
    logic       shift;
  } sched_ctl_t;

  // round unit control
  typedef struct packed {
    logic              start;
    logic              step;
    logic [RoundW-1:0] round;
    logic              fold;
    logic              reinit;
  } rnd_ctl_t;

endpackage

// ===== rtl/sha1_sched.sv =====
`timescale 1ns / 1ps

// Block buffer that doubles as the 16-word message schedule window.
module sha1_sched (
  input  logic                 clk,
  input  sha1_pkg::sched_ctl_t ctl,
  output logic [31:0]          w_o
);
  import sha1_pkg::*;

  logic [WordW-1:0] w_r [BlkWords];
  logic [WordW-1:0] w_new;
  logic [WordW-1:0] mix;
  logic [4:0]       lane_ofs;

  assign mix      = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new    = {mix[WordW-2:0], mix[WordW-1]};
  assign lane_ofs = {~ctl.byte_pos[1:0], 3'b000};  // big-endian byte lane
  assign w_o      = w_r[0];

  always_ff @(posedge clk) begin
    if (ctl.wr_byte) begin
      w_r[ctl.byte_pos[5:2]][lane_ofs +: 8] <= ctl.byte_val;
    end else if (ctl.shift) begin
      for (int i = 0; i < BlkWords - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BlkWords-1] <= w_new;
    end
  end

endmodule

// ===== rtl/sha1_round.sv =====
`timescale 1ns / 1ps

// One SHA-1 round per step, plus the chaining-value fold.
module sha1_round (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1_pkg::rnd_ctl_t ctl,
  input  logic [31:0]        w_i,
  output sha1_pkg::digest_t  h_o
);
  import sha1_pkg::*;

  digest_t          h_r;
  logic [WordW-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [WordW-1:0] f, k, t;

  always_comb begin
    if (ctl.round < RoundW'(20)) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (ctl.round < RoundW'(40)) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (ctl.round < RoundW'(60)) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_i;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (ctl.step) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.reinit) begin
      h_r <= InitChain;
    end else if (ctl.fold) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  assign h_o = h_r;

endmodule

// ===== rtl/sha1_message_digest_core.sv =====
`timescale 1ns / 1ps
// Message byte: taken while idle; a byte that completes a 64-byte block is followed
// by 80 rounds on the shared round unit and then one fold, with the input stalled.
// Finish: padding bytes go in one per cycle, each block they fill hashed the same way,
// then five digest word transfers, one per cycle while out_tready is high.
// Synchronous active-low reset loads the initial chaining values and clears the
// byte position, bit count and control; the block buffer is not cleared.
module sha1_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [63:0]       bitlen_r, bitlen_nxt;
  logic [RoundW-1:0] round_r, round_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic              fin_r, fin_nxt;        // finishing the message
  logic              mark_r, mark_nxt;      // 0x80 already placed
  logic              len_r, len_nxt;        // length bytes in progress

  sched_ctl_t        sctl;
  rnd_ctl_t          rctl;
  logic [WordW-1:0]  w_cur;
  digest_t           h;

  logic              in_xfer, out_xfer, len_sel;
  logic [7:0]        pad_byte;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign len_sel  = len_r || (pos_r == LenStart);

  always_comb begin
    if (!mark_r) begin
      pad_byte = PadMark;
    end else if (len_sel) begin
      pad_byte = bitlen_r[{~pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    bitlen_nxt = bitlen_r;
    round_nxt  = round_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    mark_nxt   = mark_r;
    len_nxt    = len_r;

    sctl       = '0;
    rctl       = '0;
    rctl.round = round_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            OpAbsorb, OpLast: begin
              sctl.wr_byte  = 1'b1;
              sctl.byte_pos = pos_r;
              sctl.byte_val = in_tdata;
              pos_nxt       = pos_r + 6'd1;
              bitlen_nxt    = bitlen_r + 64'd8;
              fin_nxt       = (in_tuser == OpLast);
              mark_nxt      = 1'b0;
              len_nxt       = 1'b0;
              if (pos_r == 6'd63) begin
                rctl.start = 1'b1;
                round_nxt  = '0;
                state_nxt  = S_ROUND;
              end else if (in_tuser == OpLast) begin
                state_nxt = S_PAD;
              end
            end
            OpFinish: begin
              fin_nxt   = 1'b1;
              mark_nxt  = 1'b0;
              len_nxt   = 1'b0;
              state_nxt = S_PAD;
            end
            default: ;  // unused op: dropped
          endcase
        end
      end
      S_PAD: begin
        sctl.wr_byte  = 1'b1;
        sctl.byte_pos = pos_r;
        sctl.byte_val = pad_byte;
        pos_nxt       = pos_r + 6'd1;
        mark_nxt      = 1'b1;
        if (mark_r && len_sel) begin
          len_nxt = 1'b1;
        end
        if (pos_r == 6'd63) begin
          rctl.start = 1'b1;
          round_nxt  = '0;
          state_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        rctl.step  = 1'b1;
        sctl.shift = 1'b1;
        round_nxt  = round_r + RoundW'(1);
        if (round_r == RoundW'(NumRounds - 1)) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        rctl.fold = 1'b1;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (len_r) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          idx_nxt = idx_r + IdxW'(1);
          if (idx_r == LastIdx) begin
            rctl.reinit = 1'b1;
            pos_nxt     = '0;
            bitlen_nxt  = '0;
            fin_nxt     = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      bitlen_r <= '0;
      round_r  <= '0;
      idx_r    <= '0;
      fin_r    <= 1'b0;
      mark_r   <= 1'b0;
      len_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      bitlen_r <= bitlen_nxt;
      round_r  <= round_nxt;
      idx_r    <= idx_nxt;
      fin_r    <= fin_nxt;
      mark_r   <= mark_nxt;
      len_r    <= len_nxt;
    end
  end

  sha1_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w_o (w_cur)
  );

  sha1_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .w_i   (w_cur),
    .h_o   (h)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = h[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == LastIdx);

  // Assertions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while digest words pending");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == LastIdx)
    else $error("last word flag on wrong index");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |=> in_tready && pos_r == '0 && bitlen_r == '0)
    else $error("chain not reinitialized after digest");

  a_plain_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == OpAbsorb && pos_r != 6'd63 |=> in_tready)
    else $error("mid-block byte stalled the input");

endmodule
